[hdl/int8mm_pkg.sv]
package int8mm_pkg;

    // Default store geometry
    localparam int MAX_A_ROWS_DEF = 128;
    localparam int MAX_B_ROWS_DEF = 512;
    localparam int MAX_DEPTH_DEF  = 512;

    // Port field widths
    localparam int CMD_W   = 2;
    localparam int AROW_W  = 7;
    localparam int BROW_W  = 9;
    localparam int IDX_W   = 9;
    localparam int ELEM_W  = 8;
    localparam int DEPTH_W = 10;
    localparam int SUM_W   = 25;
    localparam int PROD_W  = 2 * ELEM_W;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 10'd512;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_B  = 2'd1,
        CMD_COMPUTE = 2'd2
    } cmd_t;

    // Address width for a store of the given number of words
    function automatic int addr_width(input int words);
        return (words > 1) ? $clog2(words) : 1;
    endfunction

endpackage

[hdl/int8_matmul_int32_accumulate_unit.sv]
// Channel    Direction  Signals                                           Handshake
// command    in         start, cmd, a_row, b_row, elem_index, elem_value  start && !busy
// result     out        done, dot_sum, out_a_row, out_b_row               done, one cycle
// config     in         cfg_valid, cfg_ready, cfg_data                    cfg_valid && cfg_ready
//
// A load never raises busy; the next command may follow at once.
// A compute with depth D (depth_reg capped at MAX_DEPTH) keeps busy high while D
// element pairs are read from the two stores, one pair per cycle, and through ST_LAST;
// done pulses in the first cycle that busy is low again. A compute on an out-of-range row
// or with depth zero answers on the next cycle without going busy.
// rst_n clears control state and sets depth_reg to 512; store contents are not reset.
// The receiver cannot stall: each result is presented for exactly one cycle.
module int8_matmul_int32_accumulate_unit
    import int8mm_pkg::*;
#(
    parameter int MAX_A_ROWS = MAX_A_ROWS_DEF,
    parameter int MAX_B_ROWS = MAX_B_ROWS_DEF,
    parameter int MAX_DEPTH  = MAX_DEPTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    // command channel
    input  logic                     start,
    output logic                     busy,
    input  logic [CMD_W-1:0]         cmd,
    input  logic [AROW_W-1:0]        a_row,
    input  logic [BROW_W-1:0]        b_row,
    input  logic [IDX_W-1:0]         elem_index,
    input  logic signed [ELEM_W-1:0] elem_value,
    // result channel
    output logic                     done,
    output logic signed [SUM_W-1:0]  dot_sum,
    output logic [AROW_W-1:0]        out_a_row,
    output logic [BROW_W-1:0]        out_b_row,
    // configuration channel
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [DEPTH_W-1:0]       cfg_data
);

    localparam int A_WORDS = MAX_A_ROWS * MAX_DEPTH;
    localparam int B_WORDS = MAX_B_ROWS * MAX_DEPTH;
    localparam int A_AW    = addr_width(A_WORDS);
    localparam int B_AW    = addr_width(B_WORDS);
    localparam int CNT_W   = $clog2(MAX_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST
    } state_t;

    state_t                   state_reg, state_next;
    logic [DEPTH_W-1:0]       depth_reg, depth_next;
    logic [A_AW-1:0]          a_addr_reg, a_addr_next;
    logic [B_AW-1:0]          b_addr_reg, b_addr_next;
    logic [CNT_W-1:0]         remain_reg, remain_next;
    logic                     pend_reg, pend_next;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;
    logic                     done_reg, done_next;
    logic signed [SUM_W-1:0]  sum_reg, sum_next;
    logic [AROW_W-1:0]        arow_reg, arow_next;
    logic [BROW_W-1:0]        brow_reg, brow_next;

    logic                     accept;
    logic                     a_row_ok, b_row_ok, idx_ok;
    logic [CNT_W-1:0]         eff_depth;
    logic [A_AW-1:0]          a_base, a_wr_addr;
    logic [B_AW-1:0]          b_base, b_wr_addr;
    logic                     a_wr_en, b_wr_en, rd_en;
    logic [ELEM_W-1:0]        a_q, b_q;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  acc_sum;

    assign busy      = (state_reg != ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_ready = !busy;

    // Range checks and row base addresses
    assign a_row_ok  = 32'(a_row) < MAX_A_ROWS;
    assign b_row_ok  = 32'(b_row) < MAX_B_ROWS;
    assign idx_ok    = 32'(elem_index) < MAX_DEPTH;
    assign eff_depth = (32'(depth_reg) > MAX_DEPTH) ? CNT_W'(MAX_DEPTH) : CNT_W'(depth_reg);
    assign a_base    = A_AW'(32'(a_row) * MAX_DEPTH);
    assign b_base    = B_AW'(32'(b_row) * MAX_DEPTH);
    assign a_wr_addr = A_AW'(32'(a_row) * MAX_DEPTH + 32'(elem_index));
    assign b_wr_addr = B_AW'(32'(b_row) * MAX_DEPTH + 32'(elem_index));

    // Store writes for load commands
    assign a_wr_en = accept && (cmd == CMD_LOAD_A) && a_row_ok && idx_ok;
    assign b_wr_en = accept && (cmd == CMD_LOAD_B) && b_row_ok && idx_ok;
    assign rd_en   = (state_reg == ST_RUN);

    int8mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (A_WORDS)
    ) u_a_store (
        .clk     (clk),
        .wr_en   (a_wr_en),
        .wr_addr (a_wr_addr),
        .wr_data (elem_value),
        .rd_en   (rd_en),
        .rd_addr (a_addr_reg),
        .rd_data (a_q)
    );

    int8mm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (B_WORDS)
    ) u_b_store (
        .clk     (clk),
        .wr_en   (b_wr_en),
        .wr_addr (b_wr_addr),
        .wr_data (elem_value),
        .rd_en   (rd_en),
        .rd_addr (b_addr_reg),
        .rd_data (b_q)
    );

    // Multiply-accumulate on the pair read last cycle
    assign prod    = $signed(a_q) * $signed(b_q);
    assign acc_sum = acc_reg + {{(SUM_W - PROD_W){prod[PROD_W-1]}}, prod};

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        depth_next  = depth_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        remain_next = remain_reg;
        pend_next   = 1'b0;
        acc_next    = acc_reg;
        done_next   = 1'b0;
        sum_next    = sum_reg;
        arow_next   = arow_reg;
        brow_next   = brow_reg;

        if (cfg_valid && cfg_ready)
        begin
            depth_next = cfg_data;
        end

        if (pend_reg)
        begin
            acc_next = acc_sum;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (cmd == CMD_COMPUTE))
                begin
                    arow_next   = a_row;
                    brow_next   = b_row;
                    acc_next    = '0;
                    a_addr_next = a_base;
                    b_addr_next = b_base;
                    remain_next = eff_depth;
                    if (a_row_ok && b_row_ok && (eff_depth != '0))
                    begin
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        // empty sum or out-of-range row: answer at once
                        done_next = 1'b1;
                        sum_next  = '0;
                    end
                end
            end
            ST_RUN:
            begin
                // one element pair read per cycle
                pend_next   = 1'b1;
                a_addr_next = a_addr_reg + A_AW'(1);
                b_addr_next = b_addr_reg + B_AW'(1);
                remain_next = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    state_next = ST_LAST;
                end
            end
            ST_LAST:
            begin
                // final pair arrives now
                done_next  = 1'b1;
                sum_next   = acc_sum;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            depth_reg <= DEPTH_RESET;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            depth_reg <= depth_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        a_addr_reg <= a_addr_next;
        b_addr_reg <= b_addr_next;
        remain_reg <= remain_next;
        acc_reg    <= acc_next;
        sum_reg    <= sum_next;
        arow_reg   <= arow_next;
        brow_reg   <= brow_next;
    end

    assign done      = done_reg;
    assign dot_sum   = sum_reg;
    assign out_a_row = arow_reg;
    assign out_b_row = brow_reg;

endmodule

[hdl/int8mm_ram.sv]
module int8mm_ram
    import int8mm_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = addr_width(DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[sim/tb_int8_matmul_int32_accumulate_unit.sv]
`timescale 1ns / 1ps

module tb_int8_matmul_int32_accumulate_unit
    import int8mm_pkg::*;
();

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int ROW_LEN     = MAX_DEPTH_DEF;
    localparam int CHUNK_ITEMS = 8;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic [AROW_W-1:0]       a_idx;
        logic [BROW_W-1:0]       b_idx;
    } dot_result_t;

    // Mirror of both element stores and the depth register; queues dot products
    class dot_scoreboard;
        logic signed [ELEM_W-1:0] a_mem [MAX_A_ROWS_DEF][MAX_DEPTH_DEF];
        logic signed [ELEM_W-1:0] b_mem [MAX_B_ROWS_DEF][MAX_DEPTH_DEF];
        logic [DEPTH_W-1:0] depth_reg;
        dot_result_t awaited[$];
        int faults;

        function new();
            depth_reg = DEPTH_RESET;
            faults = 0;
        endfunction

        function void set_depth(logic [DEPTH_W-1:0] v);
            depth_reg = v;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void report(string msg);
            faults++;
            if (faults <= 10)
                $display("ERROR at %0t: %s", $realtime, msg);
        endfunction

        // Apply one accepted command; a compute queues its dot product
        function void note_command(logic [CMD_W-1:0] c, logic [AROW_W-1:0] ar,
                                   logic [BROW_W-1:0] br, logic [IDX_W-1:0] idx,
                                   logic signed [ELEM_W-1:0] val);
            int n;
            int acc;
            int k;
            dot_result_t r;
            if (c == CMD_LOAD_A)
                a_mem[ar][idx] = val;
            else if (c == CMD_LOAD_B)
                b_mem[br][idx] = val;
            else if (c == CMD_COMPUTE)
            begin
                // depth above the store length saturates
                n = (depth_reg > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(depth_reg);
                acc = 0;
                for (k = 0; k < n; k++)
                    acc += int'(a_mem[ar][k]) * int'(b_mem[br][k]);
                r.sum   = acc[SUM_W-1:0];
                r.a_idx = ar;
                r.b_idx = br;
                awaited.push_back(r);
            end
        endfunction

        function void check_result(logic signed [SUM_W-1:0] s, logic [AROW_W-1:0] ar,
                                   logic [BROW_W-1:0] br);
            dot_result_t e;
            if (awaited.size() == 0)
            begin
                report($sformatf("result with none outstanding: dot_sum %0d row %0d col %0d",
                                 s, ar, br));
                return;
            end
            e = awaited.pop_front();
            if (s !== e.sum || ar !== e.a_idx || br !== e.b_idx)
                report($sformatf("dot_sum %0d/%0d row %0d/%0d col %0d/%0d (exp/got)",
                                 e.sum, s, e.a_idx, ar, e.b_idx, br));
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     start;
    logic                     busy;
    logic [CMD_W-1:0]         cmd;
    logic [AROW_W-1:0]        a_row;
    logic [BROW_W-1:0]        b_row;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] elem_value;
    logic                     done;
    logic signed [SUM_W-1:0]  dot_sum;
    logic [AROW_W-1:0]        out_a_row;
    logic [BROW_W-1:0]        out_b_row;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [DEPTH_W-1:0]       cfg_data;

    dot_scoreboard sb = new();

    // Stimulus bookkeeping: which elements hold data, and the written prefix of each row
    bit a_wr [MAX_A_ROWS_DEF][MAX_DEPTH_DEF];
    bit b_wr [MAX_B_ROWS_DEF][MAX_DEPTH_DEF];
    int a_fill [MAX_A_ROWS_DEF];
    int b_fill [MAX_B_ROWS_DEF];
    int span;
    int send_idle_pct;
    int items_sent;

    int8_matmul_int32_accumulate_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .a_row      (a_row),
        .b_row      (b_row),
        .elem_index (elem_index),
        .elem_value (elem_value),
        .done       (done),
        .dot_sum    (dot_sum),
        .out_a_row  (out_a_row),
        .out_b_row  (out_b_row),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data)
    );

    always #6 clk = ~clk;

    // Results cannot be held off: take every strobe
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(dot_sum, out_a_row, out_b_row);
    end

    // One command transaction: random idle cycles, then hold start until taken
    task automatic issue(int c, int ar, int br, int idx, int val);
        logic [CMD_W-1:0]         lc;
        logic [AROW_W-1:0]        lar;
        logic [BROW_W-1:0]        lbr;
        logic [IDX_W-1:0]         lidx;
        logic signed [ELEM_W-1:0] lval;
        lc   = CMD_W'(c);
        lar  = AROW_W'(ar);
        lbr  = BROW_W'(br);
        lidx = IDX_W'(idx);
        lval = ELEM_W'(val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        cmd        <= lc;
        a_row      <= lar;
        b_row      <= lbr;
        elem_index <= lidx;
        elem_value <= lval;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(lc, lar, lbr, lidx, lval);
        if (lc != CMD_UNUSED)
            items_sent++;
        // extend the written prefix of the row just loaded
        if (lc == CMD_LOAD_A)
        begin
            a_wr[lar][lidx] = 1'b1;
            while (a_fill[lar] < ROW_LEN && a_wr[lar][a_fill[lar]])
                a_fill[lar]++;
        end
        else if (lc == CMD_LOAD_B)
        begin
            b_wr[lbr][lidx] = 1'b1;
            while (b_fill[lbr] < ROW_LEN && b_wr[lbr][b_fill[lbr]])
                b_fill[lbr]++;
        end
    endtask

    // Stop sending and let every outstanding result arrive
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_depth(int v);
        logic [DEPTH_W-1:0] lv;
        lv = DEPTH_W'(v);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= lv;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_depth(lv);
        span = (lv > MAX_DEPTH_DEF) ? MAX_DEPTH_DEF : int'(lv);
    endtask

    // Product of a random pair whose rows are written up to the current depth
    task automatic compute_ready_pair();
        int ra[$];
        int rb[$];
        int i;
        for (i = 0; i < MAX_A_ROWS_DEF; i++)
            if (a_fill[i] >= span)
                ra.push_back(i);
        for (i = 0; i < MAX_B_ROWS_DEF; i++)
            if (b_fill[i] >= span)
                rb.push_back(i);
        if (ra.size() != 0 && rb.size() != 0)
            issue(CMD_COMPUTE, ra[$urandom_range(ra.size() - 1)],
                  rb[$urandom_range(rb.size() - 1)], $urandom, $urandom);
    endtask

    // Mostly fill-then-multiply sequences; some reuse, stray loads and unused codes
    task automatic run_chunk();
        int target;
        int pick;
        int ar;
        int br;
        int k;
        target = items_sent + CHUNK_ITEMS;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
            begin
                ar = $urandom_range(MAX_A_ROWS_DEF - 1);
                br = $urandom_range(MAX_B_ROWS_DEF - 1);
                for (k = 0; k < span; k++)
                begin
                    if ($urandom_range(1))
                    begin
                        issue(CMD_LOAD_A, ar, $urandom, k, $urandom);
                        issue(CMD_LOAD_B, $urandom, br, k, $urandom);
                    end
                    else
                    begin
                        issue(CMD_LOAD_B, $urandom, br, k, $urandom);
                        issue(CMD_LOAD_A, ar, $urandom, k, $urandom);
                    end
                end
                issue(CMD_COMPUTE, ar, br, $urandom, $urandom);
            end
            else if (pick < 85)
                compute_ready_pair();
            else if (pick < 97)
                issue($urandom_range(1) ? CMD_LOAD_B : CMD_LOAD_A, $urandom, $urandom,
                      $urandom, $urandom);
            else
                issue(CMD_UNUSED, $urandom, $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        int k;
        int ph;
        int c;
        int d;
        rst_n      <= 1'b0;
        start      <= 1'b0;
        cmd        <= CMD_LOAD_A;
        a_row      <= '0;
        b_row      <= '0;
        elem_index <= '0;
        elem_value <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        span          = MAX_DEPTH_DEF;
        send_idle_pct = 37;
        items_sent    = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full rows at the reset depth: largest possible sum
        for (k = 0; k < MAX_DEPTH_DEF; k++)
        begin
            issue(CMD_LOAD_A, 127, $urandom, k, -128);
            issue(CMD_LOAD_B, $urandom, 511, k, -128);
        end
        issue(CMD_COMPUTE, 127, 511, 0, 0);

        // Oversize depth saturates to the row length
        write_depth(1023);
        issue(CMD_COMPUTE, 127, 511, 511, -1);

        // Zero depth: empty sum
        write_depth(0);
        issue(CMD_COMPUTE, 0, 0, 0, 0);
        issue(CMD_COMPUTE, 127, 510, 0, 0);

        // Single-element products at the value and index extremes
        write_depth(1);
        issue(CMD_LOAD_A, 0, 0, 0, 127);
        issue(CMD_LOAD_B, 0, 0, 0, 127);
        issue(CMD_COMPUTE, 0, 0, 0, 0);
        issue(CMD_LOAD_B, 127, 0, 0, -128);
        issue(CMD_COMPUTE, 0, 0, 511, 127);
        issue(CMD_LOAD_A, 0, 511, 0, -1);
        issue(CMD_COMPUTE, 0, 0, 0, 0);
        issue(CMD_LOAD_A, 127, 0, 511, 0);
        issue(CMD_LOAD_B, 0, 511, 511, -1);
        issue(CMD_LOAD_B, 0, 510, 0, 127);
        issue(CMD_LOAD_A, 64, 0, 0, 0);
        issue(CMD_COMPUTE, 64, 511, 0, 0);
        issue(CMD_COMPUTE, 127, 511, 0, 0);
        issue(CMD_COMPUTE, 0, 510, 0, 0);
        issue(CMD_UNUSED, 127, 511, 511, -1);
        issue(CMD_COMPUTE, 127, 0, 0, 0);

        // Random phases: sender idles often, then very often, then never
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 86 : 0;
            for (c = 0; c < 3; c++)
            begin
                case ($urandom_range(9))
                    0:       d = 0;
                    1, 2:    d = $urandom_range(13, 48);
                    default: d = $urandom_range(1, 12);
                endcase
                write_depth(d);
                run_chunk();
            end
        end

        settle();
        if (sb.faults == 0)
            $display("int8_matmul_int32_accumulate_unit: match");
        else
            $display("int8_matmul_int32_accumulate_unit: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #100_000_000;
        $display("int8_matmul_int32_accumulate_unit: mismatch");
        $finish;
    end

endmodule

[int8_matmul_int32_accumulate_unit.f]
hdl/int8mm_pkg.sv
hdl/int8mm_ram.sv
hdl/int8_matmul_int32_accumulate_unit.sv
sim/tb_int8_matmul_int32_accumulate_unit.sv
